[src/pfd_pkg.sv]
// ----------------------------------------------------------------------------
// pfd_pkg
// Types, constants and helper functions shared by the Playfair digraph
// encryption block.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam int unsigned NumLetters = 26;
   localparam int unsigned Side       = 5;
   localparam int unsigned Cells      = 25;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;

   localparam letter_type LetterI = 5'd8;
   localparam letter_type LetterJ = 5'd9;
   localparam letter_type LetterZ = 5'd25;

   localparam logic FuncKey     = 1'b0;
   localparam logic FuncEncrypt = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_CELL,
      ST_SQUARE
   } state_type;

   typedef struct packed {
      logic       en;
      letter_type letter;
   } place_type;

   typedef struct packed {
      logic       en;
      letter_type a;
      letter_type b;
   } cell_rd_type;

   typedef struct packed {
      logic     en;
      cell_type a;
      cell_type b;
   } sq_rd_type;

   function automatic letter_type clean_letter(input letter_type x);
      letter_type y;
      y = x;
      if (y >= letter_type'(NumLetters)) begin
         y = LetterZ;
      end
      if (y == LetterJ) begin
         y = LetterI;
      end
      return y;
   endfunction

   function automatic coord_type cell_row(input cell_type c);
      coord_type r;
      priority if (c >= 5'd20) begin
         r = 3'd4;
      end else if (c >= 5'd15) begin
         r = 3'd3;
      end else if (c >= 5'd10) begin
         r = 3'd2;
      end else if (c >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic coord_type cell_col(input cell_type c);
      cell_type base;
      cell_type diff;
      base = cell_type'({2'b00, cell_row(c)}) * cell_type'(Side);
      diff = c - base;
      return diff[2:0];
   endfunction

   function automatic cell_type make_cell(input coord_type row, input coord_type col);
      return cell_type'({2'b00, row}) * cell_type'(Side) + cell_type'({2'b00, col});
   endfunction

   function automatic coord_type wrap_inc(input coord_type x);
      coord_type y;
      if (x == coord_type'(Side - 1)) begin
         y = '0;
      end else begin
         y = x + 3'd1;
      end
      return y;
   endfunction

endpackage

[src/pfd_intf.sv]
// ----------------------------------------------------------------------------
// pfd_intf
// Valid/ready channels of the Playfair block: request and response.
// ----------------------------------------------------------------------------
interface pfd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [4:0] letter_a;
   logic [4:0] letter_b;
   logic       pad_b;
   logic       last_key;

   modport source (output valid, func, letter_a, letter_b, pad_b, last_key, input ready);
   modport sink   (input valid, func, letter_a, letter_b, pad_b, last_key, output ready);
endinterface

interface pfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] cipher_a;
   logic [4:0] cipher_b;

   modport source (output valid, cipher_a, cipher_b, input ready);
   modport sink   (input valid, cipher_a, cipher_b, output ready);
endinterface

[src/pfd_keysq.sv]
// ----------------------------------------------------------------------------
// pfd_keysq
// Key square store: placement of letters, letter-to-cell and cell-to-letter
// memories with registered reads.
// ----------------------------------------------------------------------------
module pfd_keysq (
   input  logic                  clock,
   input  logic                  reset,
   input  pfd_pkg::place_type    place,
   input  pfd_pkg::cell_rd_type  cell_rd,
   input  pfd_pkg::sq_rd_type    sq_rd,
   output pfd_pkg::cell_type     cell_a,
   output pfd_pkg::cell_type     cell_b,
   output pfd_pkg::letter_type   sq_a,
   output pfd_pkg::letter_type   sq_b
);
   import pfd_pkg::*;

   // j is never placed
   localparam logic [NumLetters-1:0] UsedReset = {{(NumLetters - 1){1'b0}}, 1'b1} << LetterJ;

   logic [NumLetters-1:0] letter_used_ff;
   logic [NumLetters-1:0] letter_used_in;
   cell_type              fill_count_ff;
   cell_type              fill_count_in;
   logic                  place_ok;

   letter_type square_mem [Cells];
   cell_type   cell_mem   [NumLetters];

   cell_type   cell_a_ff;
   cell_type   cell_b_ff;
   letter_type sq_a_ff;
   letter_type sq_b_ff;

   always_comb begin
      place_ok = 1'b0;
      if (place.en && (place.letter < letter_type'(NumLetters))
          && (fill_count_ff < cell_type'(Cells))) begin
         place_ok = !letter_used_ff[place.letter];
      end
   end

   always_comb begin
      letter_used_in = letter_used_ff;
      fill_count_in  = fill_count_ff;
      if (place_ok) begin
         letter_used_in[place.letter] = 1'b1;
         fill_count_in                = fill_count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_used_ff <= UsedReset;
         fill_count_ff  <= '0;
      end else begin
         letter_used_ff <= letter_used_in;
         fill_count_ff  <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (place_ok) begin
         square_mem[fill_count_ff] <= place.letter;
         cell_mem[place.letter]    <= fill_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_rd.en) begin
         cell_a_ff <= cell_mem[cell_rd.a];
         cell_b_ff <= cell_mem[cell_rd.b];
      end
   end

   always_ff @(posedge clock) begin
      if (sq_rd.en) begin
         sq_a_ff <= square_mem[sq_rd.a];
         sq_b_ff <= square_mem[sq_rd.b];
      end
   end

   assign cell_a = cell_a_ff;
   assign cell_b = cell_b_ff;
   assign sq_a   = sq_a_ff;
   assign sq_b   = sq_b_ff;

endmodule

[src/playfair_digraph_encrypt.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair cipher with an on-chip 5x5 key square, built from key letters and
// then used to encipher digraphs.
// ----------------------------------------------------------------------------
// Letters are coded 0 = a .. 25 = z. Send key letters first (func = 0), one per
// transaction; repeats and j are skipped, and the transaction with last_key set
// starts a walk that appends every unused letter, after which the square is
// ready and further key letters are ignored. The walk places one letter of the
// alphabet per cycle through the single placement port. A digraph (func = 1)
// passes a registered letter-to-cell lookup, a registered cell-to-letter read,
// then the output register, which waits while the output is stalled. Digraphs
// sent before the square is ready give no response. No clearing pass is needed
// after reset.
module playfair_digraph_encrypt (
   input logic       clock,
   input logic       reset,
   pfd_req_if.sink   req_chan,
   pfd_rsp_if.source rsp_chan
);
   import pfd_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   logic        sq_ready_ff;
   logic        sq_ready_in;
   letter_type  walk_ff;
   letter_type  walk_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   letter_type  cipher_a_ff;
   letter_type  cipher_b_ff;

   logic        req_accept;
   logic        out_free;
   logic        out_load;

   place_type   place;
   cell_rd_type cell_rd;
   sq_rd_type   sq_rd;
   cell_type    cell_a;
   cell_type    cell_b;
   letter_type  sq_a;
   letter_type  sq_b;

   coord_type   row_a;
   coord_type   col_a;
   coord_type   row_b;
   coord_type   col_b;

   pfd_keysq u_keysq (
      .clock   (clock),
      .reset   (reset),
      .place   (place),
      .cell_rd (cell_rd),
      .sq_rd   (sq_rd),
      .cell_a  (cell_a),
      .cell_b  (cell_b),
      .sq_a    (sq_a),
      .sq_b    (sq_b)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign row_a = cell_row(cell_a);
   assign col_a = cell_col(cell_a);
   assign row_b = cell_row(cell_b);
   assign col_b = cell_col(cell_b);

   // next state
   always_comb begin
      state_in    = state_ff;
      sq_ready_in = sq_ready_ff;
      walk_in     = walk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && sq_ready_ff && (req_chan.func == FuncEncrypt)) begin
               state_in = ST_CELL;
            end else if (req_accept && !sq_ready_ff && (req_chan.func == FuncKey)
                         && req_chan.last_key) begin
               state_in = ST_FILL;
               walk_in  = '0;
            end
         end
         ST_FILL: begin
            walk_in = walk_ff + 5'd1;
            if (walk_ff == letter_type'(NumLetters - 1)) begin
               state_in    = ST_IDLE;
               sq_ready_in = 1'b1;
            end
         end
         ST_CELL: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      place    = '0;
      cell_rd  = '0;
      sq_rd    = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            place.en     = req_accept && !sq_ready_ff && (req_chan.func == FuncKey);
            place.letter = req_chan.letter_a;
            cell_rd.en   = req_accept && sq_ready_ff && (req_chan.func == FuncEncrypt);
            cell_rd.a    = clean_letter(req_chan.letter_a);
            cell_rd.b    = req_chan.pad_b ? LetterZ : clean_letter(req_chan.letter_b);
         end
         ST_FILL: begin
            place.en     = 1'b1;
            place.letter = walk_ff;
         end
         ST_CELL: begin
            sq_rd.en = 1'b1;
            priority if (row_a == row_b) begin
               sq_rd.a = make_cell(row_a, wrap_inc(col_a));
               sq_rd.b = make_cell(row_b, wrap_inc(col_b));
            end else if (col_a == col_b) begin
               sq_rd.a = make_cell(wrap_inc(row_a), col_a);
               sq_rd.b = make_cell(wrap_inc(row_b), col_b);
            end else begin
               sq_rd.a = make_cell(row_a, col_b);
               sq_rd.b = make_cell(row_b, col_a);
            end
         end
         ST_SQUARE: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sq_ready_ff  <= 1'b0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sq_ready_ff  <= sq_ready_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         cipher_a_ff <= sq_a;
         cipher_b_ff <= sq_b;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.cipher_a = cipher_a_ff;
   assign rsp_chan.cipher_b = cipher_b_ff;

endmodule
